/* rtl/core/ipv4_tcp_udp_header_filter_top_defines.svh */
// assertion macros for the header filter checker
// no dependencies; included by the checker file only
`ifndef IPV4_TCP_UDP_HEADER_FILTER_TOP_DEFINES_SVH
`define IPV4_TCP_UDP_HEADER_FILTER_TOP_DEFINES_SVH

// condition holds on every edge out of reset
`define IHF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define IHF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ihf_pkg.sv */
// types and constants of the ipv4 tcp/udp header filter
// no dependencies; imported by every module of the block
package ihf_pkg;

    localparam logic [2:0] ST_NOT_IPV4      = 3'd0;
    localparam logic [2:0] ST_PASS_L4       = 3'd1;
    localparam logic [2:0] ST_PASS_NO_L4    = 3'd2;
    localparam logic [2:0] ST_FAIL_SRC_IP   = 3'd3;
    localparam logic [2:0] ST_FAIL_DST_IP   = 3'd4;
    localparam logic [2:0] ST_FAIL_SRC_PORT = 3'd5;
    localparam logic [2:0] ST_FAIL_DST_PORT = 3'd6;
    localparam logic [2:0] ST_PENDING       = 3'd7;

    localparam logic [1:0] REG_SRC_IP   = 2'd0;
    localparam logic [1:0] REG_DST_IP   = 2'd1;
    localparam logic [1:0] REG_SRC_PORT = 2'd2;
    localparam logic [1:0] REG_DST_PORT = 2'd3;

    localparam logic [10:0] POS_MAX       = 11'd2047;
    localparam logic [15:0] ETHERTYPE_IP4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [10:0] ETH_HDR_BYTES = 11'd14;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ihf_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  header_bytes;
        logic [7:0]  service_type;
        logic [15:0] total_length;
        logic [12:0] fragment_offset;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] udp_length;
    } ihf_out_t;

    typedef struct packed {
        logic [31:0] src_ip_filter;
        logic [31:0] dst_ip_filter;
        logic [15:0] src_port_filter;
        logic [15:0] dst_port_filter;
    } ihf_cfg_t;

endpackage

/* rtl/core/ipv4_tcp_udp_header_filter_top.sv */
// ipv4 tcp/udp header filter: one frame byte per cycle while frame_stall is low, one verdict per frame
// the verdict request is registered in the result register, or in the skid slot while result_stall holds it
// throughput: one byte per cycle while frame_stall is low; the parser state updates on each accepted byte
// frame_stall rises only while both result slots are full under result_stall
// reset clears frame state, filters to zero (all checks off) and the result slots
// depends on ihf_pkg, ihf_cfg, ihf_parser, ihf_out_skid
module ipv4_tcp_udp_header_filter_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  ihf_pkg::ihf_in_t  frame_data,
    output logic              result_valid,
    input  logic              result_stall,
    output ihf_pkg::ihf_out_t result_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ihf_pkg::*;

    ihf_cfg_t cfg;
    ihf_out_t res_data;
    logic     res_valid;
    logic     accept;
    logic     full;

    assign frame_stall = full;
    assign accept      = frame_valid && !full;

    ihf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ihf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (frame_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    ihf_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .full      (full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result_data)
    );

endmodule

/* rtl/core/ihf_cfg.sv */
// apb configuration registers of the header filter
// depends on ihf_pkg
module ihf_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output ihf_pkg::ihf_cfg_t cfg
);
    import ihf_pkg::*;

    ihf_cfg_t   cfg_reg;
    ihf_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SRC_IP:   cfg_next.src_ip_filter   = pwdata;
                REG_DST_IP:   cfg_next.dst_ip_filter   = pwdata;
                REG_SRC_PORT: cfg_next.src_port_filter = pwdata[15:0];
                REG_DST_PORT: cfg_next.dst_port_filter = pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SRC_IP:   prdata = cfg_reg.src_ip_filter;
            REG_DST_IP:   prdata = cfg_reg.dst_ip_filter;
            REG_SRC_PORT: prdata = {16'd0, cfg_reg.src_port_filter};
            REG_DST_PORT: prdata = {16'd0, cfg_reg.dst_port_filter};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/ihf_parser.sv */
// per-byte header parser and filter: frame state and verdict
// depends on ihf_pkg
module ihf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ihf_pkg::ihf_in_t  in_data,
    input  ihf_pkg::ihf_cfg_t cfg,
    output logic              res_valid,
    output ihf_pkg::ihf_out_t res_data
);
    import ihf_pkg::*;

    logic [10:0] pos_reg,     pos_next;
    logic [15:0] ether_reg,   ether_upd;
    logic [5:0]  ihl_reg,     ihl_upd;
    logic [7:0]  tos_reg,     tos_upd;
    logic [15:0] tlen_reg,    tlen_upd;
    logic [12:0] frag_reg,    frag_upd;
    logic [7:0]  ttl_reg,     ttl_upd;
    logic [7:0]  proto_reg,   proto_upd;
    logic [31:0] saddr_reg,   saddr_upd;
    logic [31:0] daddr_reg,   daddr_upd;
    logic [15:0] sport_reg,   sport_upd;
    logic [15:0] dport_reg,   dport_upd;
    logic [15:0] ulen_reg,    ulen_upd;
    logic [2:0]  verdict_reg, verdict_upd;

    logic [2:0]  verdict_cur;
    logic [10:0] l4_start;
    logic [10:0] l4_off;
    logic        in_l4;
    logic        l4_enabled;
    logic [7:0]  b;
    logic [5:0]  ihl_raw;

    assign b          = in_data.data_byte;
    assign ihl_raw    = {b[3:0], 2'b00};
    assign verdict_cur = (pos_reg == 11'd0) ? ST_PENDING : verdict_reg;
    assign l4_start   = ETH_HDR_BYTES + {5'd0, ihl_reg};
    assign l4_off     = pos_reg - l4_start;
    assign in_l4      = (pos_reg >= l4_start) && (l4_off < 11'd6);
    assign l4_enabled = (frag_reg == 13'd0)
                        && ((proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP));

    always_comb
    begin
        ether_upd   = ether_reg;
        ihl_upd     = ihl_reg;
        tos_upd     = tos_reg;
        tlen_upd    = tlen_reg;
        frag_upd    = frag_reg;
        ttl_upd     = ttl_reg;
        proto_upd   = proto_reg;
        saddr_upd   = saddr_reg;
        daddr_upd   = daddr_reg;
        sport_upd   = sport_reg;
        dport_upd   = dport_reg;
        ulen_upd    = ulen_reg;
        verdict_upd = verdict_cur;
        if (verdict_cur == ST_PENDING)
        begin
            priority if (pos_reg == 11'd12 || pos_reg == 11'd13)
            begin
                ether_upd = {ether_reg[7:0], b};
                if (pos_reg == 11'd13 && ether_upd != ETHERTYPE_IP4)
                    verdict_upd = ST_NOT_IPV4;
            end
            else if (pos_reg == 11'd14)
            begin
                if (b[7:4] != 4'h4)
                    verdict_upd = ST_NOT_IPV4;
                else if (ihl_raw < MIN_HDR_BYTES)
                    ihl_upd = MIN_HDR_BYTES;
                else
                    ihl_upd = ihl_raw;
            end
            else if (pos_reg == 11'd15)
            begin
                tos_upd = b;
            end
            else if (pos_reg == 11'd16 || pos_reg == 11'd17)
            begin
                tlen_upd = {tlen_reg[7:0], b};
            end
            else if (pos_reg == 11'd20)
            begin
                frag_upd = {b[4:0], 8'd0};
            end
            else if (pos_reg == 11'd21)
            begin
                frag_upd = {frag_reg[12:8], b};
            end
            else if (pos_reg == 11'd22)
            begin
                ttl_upd = b;
            end
            else if (pos_reg == 11'd23)
            begin
                proto_upd = b;
            end
            else if (pos_reg >= 11'd26 && pos_reg <= 11'd29)
            begin
                saddr_upd = {saddr_reg[23:0], b};
                if (pos_reg == 11'd29 && cfg.src_ip_filter[31:24] != 8'd0
                    && saddr_upd != cfg.src_ip_filter)
                    verdict_upd = ST_FAIL_SRC_IP;
            end
            else if (pos_reg >= 11'd30 && pos_reg <= 11'd33)
            begin
                daddr_upd = {daddr_reg[23:0], b};
                if (pos_reg == 11'd33)
                begin
                    if (cfg.dst_ip_filter[31:24] != 8'd0 && daddr_upd != cfg.dst_ip_filter)
                        verdict_upd = ST_FAIL_DST_IP;
                    else if (!l4_enabled)
                        verdict_upd = ST_PASS_NO_L4;
                end
            end
            else if (in_l4)
            begin
                unique case (l4_off[2:1])
                    2'd0:    sport_upd = {sport_reg[7:0], b};
                    2'd1:    dport_upd = {dport_reg[7:0], b};
                    default: ulen_upd  = {ulen_reg[7:0], b};
                endcase
                priority if (l4_off == 11'd1)
                begin
                    if (cfg.src_port_filter != 16'd0 && sport_upd != cfg.src_port_filter)
                        verdict_upd = ST_FAIL_SRC_PORT;
                end
                else if (l4_off == 11'd3)
                begin
                    if (cfg.dst_port_filter != 16'd0 && dport_upd != cfg.dst_port_filter)
                        verdict_upd = ST_FAIL_DST_PORT;
                    else if (proto_reg != PROTO_UDP)
                        verdict_upd = ST_PASS_L4;
                end
                else if (l4_off == 11'd5)
                begin
                    verdict_upd = ST_PASS_L4;
                end
                else
                begin
                end
            end
            else
            begin
            end
        end
    end

    always_comb
    begin
        res_valid                    = accept && in_data.last_byte;
        res_data.status              = verdict_upd;
        res_data.header_bytes        = ihl_upd;
        res_data.service_type        = tos_upd;
        res_data.total_length        = tlen_upd;
        res_data.fragment_offset     = frag_upd;
        res_data.time_to_live        = ttl_upd;
        res_data.protocol_number     = proto_upd;
        res_data.source_address      = saddr_upd;
        res_data.destination_address = daddr_upd;
        res_data.source_port         = sport_upd;
        res_data.destination_port    = dport_upd;
        res_data.udp_length          = (proto_upd == PROTO_UDP) ? ulen_upd : 16'd0;
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 11'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            ether_reg   <= '0;
            ihl_reg     <= '0;
            tos_reg     <= '0;
            tlen_reg    <= '0;
            frag_reg    <= '0;
            ttl_reg     <= '0;
            proto_reg   <= '0;
            saddr_reg   <= '0;
            daddr_reg   <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
            ulen_reg    <= '0;
            verdict_reg <= ST_NOT_IPV4;
        end
        else if (accept)
        begin
            if (in_data.last_byte)
            begin
                pos_reg     <= '0;
                ether_reg   <= '0;
                ihl_reg     <= '0;
                tos_reg     <= '0;
                tlen_reg    <= '0;
                frag_reg    <= '0;
                ttl_reg     <= '0;
                proto_reg   <= '0;
                saddr_reg   <= '0;
                daddr_reg   <= '0;
                sport_reg   <= '0;
                dport_reg   <= '0;
                ulen_reg    <= '0;
                verdict_reg <= ST_NOT_IPV4;
            end
            else
            begin
                pos_reg     <= pos_next;
                ether_reg   <= ether_upd;
                ihl_reg     <= ihl_upd;
                tos_reg     <= tos_upd;
                tlen_reg    <= tlen_upd;
                frag_reg    <= frag_upd;
                ttl_reg     <= ttl_upd;
                proto_reg   <= proto_upd;
                saddr_reg   <= saddr_upd;
                daddr_reg   <= daddr_upd;
                sport_reg   <= sport_upd;
                dport_reg   <= dport_upd;
                ulen_reg    <= ulen_upd;
                verdict_reg <= verdict_upd;
            end
        end
    end

endmodule

/* rtl/core/ihf_out_skid.sv */
// result register with skid slot for the verdict request
// depends on ihf_pkg
module ihf_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  ihf_pkg::ihf_out_t res_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output ihf_pkg::ihf_out_t out_data
);
    import ihf_pkg::*;

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    ihf_out_t out_data_reg, out_data_next;
    ihf_out_t skid_data_reg, skid_data_next;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (out_valid_reg && !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
            begin
                out_data_next = res_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (res_valid)
            begin
                skid_data_next  = res_data;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            if (res_valid)
            begin
                out_data_next  = res_data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* rtl/core/ihf_checker.sv */
// port-level checks of the header filter, bound to the top level
// depends on ihf_pkg and ipv4_tcp_udp_header_filter_top_defines.svh
`include "ipv4_tcp_udp_header_filter_top_defines.svh"

module ihf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_stall,
    input ihf_pkg::ihf_in_t  frame_data,
    input logic              result_valid,
    input logic              result_stall,
    input ihf_pkg::ihf_out_t result_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [3:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);
    import ihf_pkg::*;

    // stalled request holds
    `IHF_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_data), "stalled result request changed")

    // not_ipv4 freezes before any ip field is taken
    `IHF_ASSERT_IMPLY(a_not_ipv4_zero, clk, rst_n, result_valid && result_data.status == ST_NOT_IPV4, result_data.source_address == 32'd0 && result_data.total_length == 16'd0 && result_data.source_port == 16'd0, "not_ipv4 verdict carries captured fields")

    // pass and ip-filter fail verdicts, all past the version byte, carry a clamped header length
    `IHF_ASSERT_IMPLY(a_hdr_len, clk, rst_n, result_valid && (result_data.status == ST_PASS_L4 || result_data.status == ST_PASS_NO_L4 || result_data.status == ST_FAIL_SRC_IP || result_data.status == ST_FAIL_DST_IP), result_data.header_bytes >= MIN_HDR_BYTES, "header length below minimum")

    // udp length only for udp
    `IHF_ASSERT_IMPLY(a_udp_len, clk, rst_n, result_valid && result_data.udp_length != 16'd0, result_data.protocol_number == PROTO_UDP, "udp length on non-udp frame")

endmodule

bind ipv4_tcp_udp_header_filter_top ihf_checker u_ihf_checker (.*);

/* bench/ipv4_tcp_udp_header_filter_top_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the ipv4 tcp/udp header filter: frames fed a byte at a time
// against an in-bench header parser, verdicts checked field by field, filters set over apb
// depends on ihf_pkg and ipv4_tcp_udp_header_filter_top
module ipv4_tcp_udp_header_filter_top_tb;
    import ihf_pkg::*;

    localparam int          LIMIT_CYCLES  = 800000;
    localparam int          DRAIN_SETTLE  = 4;
    localparam logic [3:0]  IP_VERSION_4  = 4'h4;
    localparam ihf_cfg_t    CFG_OFF       = '0;
    localparam ihf_cfg_t    CFG_A         = {32'hC0A8_0001, 32'h0A00_0001, 16'h1234, 16'hFFFF};
    localparam ihf_cfg_t    CFG_B         = {32'hFFFF_FFFF, 32'h00FF_FFFF, 16'h0000, 16'hFFFF};

    typedef struct packed {
        logic [15:0] eth_type;
        logic [7:0]  ver_ihl;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [11:0] nbytes;
        ihf_cfg_t    cfg;
        logic        typed;
        logic [2:0]  typed_status;
    } frame_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        frame_valid  = 1'b0;
    logic        frame_stall;
    ihf_in_t     frame_data   = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    ihf_out_t    result_data;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    ihf_out_t    verdict_q[$];
    frame_row_t  directed_rows[$];
    ihf_cfg_t    filter_cfg   = '0;
    bit          idle_on      = 1'b1;
    int          mismatches   = 0;
    int          sent_bytes   = 0;
    int          cycles       = 0;
    int          stall_left   = 0;

    // parser state of the in-bench header model
    logic [10:0] cur_pos        = '0;
    logic [15:0] cur_ether_type = '0;
    logic [5:0]  cur_hdr_bytes  = '0;
    logic [7:0]  cur_tos        = '0;
    logic [15:0] cur_total_len  = '0;
    logic [12:0] cur_frag       = '0;
    logic [7:0]  cur_ttl        = '0;
    logic [7:0]  cur_proto      = '0;
    logic [31:0] cur_src        = '0;
    logic [31:0] cur_dst        = '0;
    logic [15:0] cur_ports[3]   = '{16'h0, 16'h0, 16'h0};
    logic [2:0]  cur_verdict    = ST_NOT_IPV4;

    ipv4_tcp_udp_header_filter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_data   (frame_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int hdr_len(input logic [7:0] ver_ihl);
        return (ver_ihl[3:0] < 4'd5) ? 20 : 4 * ver_ihl[3:0];
    endfunction

    // frame length that ends exactly on the byte where a passing verdict becomes final
    function automatic int natural_len(input frame_row_t row);
        int l4;
        l4 = 14 + hdr_len(row.ver_ihl);
        if (row.frag[12:0] != 13'h0)
            return 34;
        if (row.proto == PROTO_TCP)
            return l4 + 4;
        if (row.proto == PROTO_UDP)
            return l4 + 6;
        return 34;
    endfunction

    function automatic logic [7:0] frame_byte(input frame_row_t row, input int p);
        int l4;
        l4 = 14 + hdr_len(row.ver_ihl);
        if (p == 12)
            return row.eth_type[15:8];
        if (p == 13)
            return row.eth_type[7:0];
        if (p == 14)
            return row.ver_ihl;
        if (p == 20)
            return row.frag[15:8];
        if (p == 21)
            return row.frag[7:0];
        if (p == 23)
            return row.proto;
        if (p >= 26 && p <= 29)
            return row.src[8 * (29 - p) +: 8];
        if (p >= 30 && p <= 33)
            return row.dst[8 * (33 - p) +: 8];
        if (p >= l4 && p < l4 + 2)
            return row.sport[8 * (l4 + 1 - p) +: 8];
        if (p >= l4 + 2 && p < l4 + 4)
            return row.dport[8 * (l4 + 3 - p) +: 8];
        return 8'($urandom);
    endfunction

    function automatic frame_row_t random_row(input ihf_cfg_t cfg);
        frame_row_t row;
        int         r;
        int         nat;
        logic [3:0] nib;
        row = '0;
        row.cfg = cfg;
        row.eth_type = ETHERTYPE_IP4;
        r = $urandom_range(0, 9);
        if (r < 6)
            nib = 4'd5;
        else if (r < 8)
            nib = 4'($urandom_range(6, 15));
        else
            nib = 4'($urandom_range(0, 4));
        row.ver_ihl = {IP_VERSION_4, nib};
        r = $urandom_range(0, 9);
        if (r < 4)
            row.proto = PROTO_TCP;
        else if (r < 8)
            row.proto = PROTO_UDP;
        else
            row.proto = 8'($urandom);
        row.frag = 16'($urandom);
        if ($urandom_range(0, 6) != 0)
            row.frag[12:0] = 13'h0;
        row.src   = ($urandom_range(0, 2) != 0) ? cfg.src_ip_filter : $urandom;
        row.dst   = ($urandom_range(0, 2) != 0) ? cfg.dst_ip_filter : $urandom;
        row.sport = ($urandom_range(0, 2) != 0) ? cfg.src_port_filter : 16'($urandom);
        row.dport = ($urandom_range(0, 2) != 0) ? cfg.dst_port_filter : 16'($urandom);
        nat = natural_len(row);
        row.nbytes = 12'(nat + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0));
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            if (r < 6)
                row.eth_type = 16'($urandom);
            else
            begin
                nib = 4'($urandom_range(0, 14));
                if (nib >= IP_VERSION_4)
                    nib++;
                row.ver_ihl[7:4] = nib;
            end
            row.nbytes = 12'($urandom_range(14, 60));
        end
        else if (r < 24)
            row.nbytes = 12'($urandom_range(1, nat - 1));
        return row;
    endfunction

    task automatic predict_header_byte(input logic [7:0] data, input logic eof,
                                       output bit has_verdict, output ihf_out_t pred);
        int p;
        int l4;
        int k;
        p = cur_pos;
        l4 = 14 + cur_hdr_bytes;
        pred = '0;
        if (cur_pos == 11'd0)
            cur_verdict = ST_PENDING;
        if (cur_verdict == ST_PENDING)
        begin
            if (p == 12 || p == 13)
            begin
                cur_ether_type = {cur_ether_type[7:0], data};
                if (p == 13 && cur_ether_type != ETHERTYPE_IP4)
                    cur_verdict = ST_NOT_IPV4;
            end
            else if (p == 14)
            begin
                if (data[7:4] != IP_VERSION_4)
                    cur_verdict = ST_NOT_IPV4;
                else
                    cur_hdr_bytes = (data[3:0] < 4'd5) ? MIN_HDR_BYTES : {data[3:0], 2'b00};
            end
            else if (p == 15)
                cur_tos = data;
            else if (p == 16 || p == 17)
                cur_total_len = {cur_total_len[7:0], data};
            else if (p == 20)
                cur_frag = {data[4:0], 8'h00};
            else if (p == 21)
                cur_frag = {cur_frag[12:8], data};
            else if (p == 22)
                cur_ttl = data;
            else if (p == 23)
                cur_proto = data;
            else if (p >= 26 && p <= 29)
            begin
                cur_src = {cur_src[23:0], data};
                if (p == 29 && filter_cfg.src_ip_filter[31:24] != 8'h0
                    && cur_src != filter_cfg.src_ip_filter)
                    cur_verdict = ST_FAIL_SRC_IP;
            end
            else if (p >= 30 && p <= 33)
            begin
                cur_dst = {cur_dst[23:0], data};
                if (p == 33)
                begin
                    if (filter_cfg.dst_ip_filter[31:24] != 8'h0
                        && cur_dst != filter_cfg.dst_ip_filter)
                        cur_verdict = ST_FAIL_DST_IP;
                    else if (!(cur_frag == 13'h0
                               && (cur_proto == PROTO_TCP || cur_proto == PROTO_UDP)))
                        cur_verdict = ST_PASS_NO_L4;
                end
            end
            else if (p >= l4 && p < l4 + 6)
            begin
                k = (p - l4) / 2;
                cur_ports[k] = {cur_ports[k][7:0], data};
                if (p == l4 + 1)
                begin
                    if (filter_cfg.src_port_filter != 16'h0
                        && cur_ports[0] != filter_cfg.src_port_filter)
                        cur_verdict = ST_FAIL_SRC_PORT;
                end
                else if (p == l4 + 3)
                begin
                    if (filter_cfg.dst_port_filter != 16'h0
                        && cur_ports[1] != filter_cfg.dst_port_filter)
                        cur_verdict = ST_FAIL_DST_PORT;
                    else if (cur_proto != PROTO_UDP)
                        cur_verdict = ST_PASS_L4;
                end
                else if (p == l4 + 5)
                    cur_verdict = ST_PASS_L4;
            end
        end
        if (cur_pos < POS_MAX)
            cur_pos++;
        has_verdict = eof;
        if (eof)
        begin
            pred.status              = cur_verdict;
            pred.header_bytes        = cur_hdr_bytes;
            pred.service_type        = cur_tos;
            pred.total_length        = cur_total_len;
            pred.fragment_offset     = cur_frag;
            pred.time_to_live        = cur_ttl;
            pred.protocol_number     = cur_proto;
            pred.source_address      = cur_src;
            pred.destination_address = cur_dst;
            pred.source_port         = cur_ports[0];
            pred.destination_port    = cur_ports[1];
            pred.udp_length          = (cur_proto == PROTO_UDP) ? cur_ports[2] : 16'h0;
            cur_pos        = '0;
            cur_ether_type = '0;
            cur_hdr_bytes  = '0;
            cur_tos        = '0;
            cur_total_len  = '0;
            cur_frag       = '0;
            cur_ttl        = '0;
            cur_proto      = '0;
            cur_src        = '0;
            cur_dst        = '0;
            foreach (cur_ports[i])
                cur_ports[i] = '0;
            cur_verdict    = ST_NOT_IPV4;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic eof, input logic typed,
                             input logic [2:0] typed_status);
        int       gap;
        bit       got;
        ihf_out_t pred;
        ihf_in_t  req;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap != 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.data_byte = data;
        req.last_byte = eof;
        frame_valid <= 1'b1;
        frame_data  <= req;
        do
            @(posedge clk);
        while (frame_stall);
        sent_bytes++;
        predict_header_byte(data, eof, got, pred);
        if (got)
        begin
            if (typed)
            begin
                pred = '0;
                pred.status = typed_status;
            end
            verdict_q.push_back(pred);
        end
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_row_t row);
        int n;
        n = (row.nbytes != 12'h0) ? row.nbytes : natural_len(row);
        for (int i = 0; i < n; i++)
            send_byte(frame_byte(row, i), i == n - 1, row.typed, row.typed_status);
    endtask

    task automatic wait_drained();
        frame_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
    endtask

    task automatic apply_filters(input ihf_cfg_t cfg);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, REG_SRC_IP, cfg.src_ip_filter, rd);
        apb_access(1'b1, REG_DST_IP, cfg.dst_ip_filter, rd);
        apb_access(1'b1, REG_SRC_PORT, {16'h0, cfg.src_port_filter}, rd);
        apb_access(1'b1, REG_DST_PORT, {16'h0, cfg.dst_port_filter}, rd);
        apb_access(1'b0, REG_SRC_IP, '0, rd);
        check_field("src_ip_filter readback", cfg.src_ip_filter, rd);
        apb_access(1'b0, REG_DST_IP, '0, rd);
        check_field("dst_ip_filter readback", cfg.dst_ip_filter, rd);
        apb_access(1'b0, REG_SRC_PORT, '0, rd);
        check_field("src_port_filter readback", {16'h0, cfg.src_port_filter}, rd);
        apb_access(1'b0, REG_DST_PORT, '0, rd);
        check_field("dst_port_filter readback", {16'h0, cfg.dst_port_filter}, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        filter_cfg = cfg;
    endtask

    task automatic add_row(input logic [15:0] eth_type, input logic [7:0] ver_ihl,
                           input logic [15:0] frag, input logic [7:0] proto,
                           input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] sport, input logic [15:0] dport,
                           input logic [11:0] nbytes, input ihf_cfg_t cfg,
                           input logic typed, input logic [2:0] typed_status);
        frame_row_t row;
        row = {eth_type, ver_ihl, frag, proto, src, dst, sport, dport, nbytes, cfg,
               typed, typed_status};
        directed_rows.push_back(row);
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else if (!idle_on)
        begin
            result_stall <= 1'b0;
            stall_left = $urandom_range(4, 16);
        end
        else if ($urandom_range(0, 99) < 35)
        begin
            result_stall <= 1'b1;
            stall_left = gap_len();
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin : check_verdict
        ihf_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t verdict with none expected, status %0d", $time,
                             result_data.status);
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("status", want.status, result_data.status);
                check_field("header_bytes", want.header_bytes, result_data.header_bytes);
                check_field("service_type", want.service_type, result_data.service_type);
                check_field("total_length", want.total_length, result_data.total_length);
                check_field("fragment_offset", want.fragment_offset,
                            result_data.fragment_offset);
                check_field("time_to_live", want.time_to_live, result_data.time_to_live);
                check_field("protocol_number", want.protocol_number,
                            result_data.protocol_number);
                check_field("source_address", want.source_address,
                            result_data.source_address);
                check_field("destination_address", want.destination_address,
                            result_data.destination_address);
                check_field("source_port", want.source_port, result_data.source_port);
                check_field("destination_port", want.destination_port,
                            result_data.destination_port);
                check_field("udp_length", want.udp_length, result_data.udp_length);
            end
        end
    end

    initial
    begin
        frame_row_t row;
        ihf_cfg_t   cfg;
        int         phase;

        // eth type, ver/ihl, flags+offset, proto, src, dst, sport, dport, bytes, filters
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd1,
                CFG_OFF, 1'b1, ST_PENDING);
        add_row(16'h86DD, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd20,
                CFG_OFF, 1'b1, ST_NOT_IPV4);
        add_row(16'h0800, 8'h65, 16'h0000, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd40,
                CFG_OFF, 1'b1, ST_NOT_IPV4);
        add_row(16'h0000, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd14,
                CFG_OFF, 1'b1, ST_NOT_IPV4);
        add_row(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                16'hFFFF, 12'd60, CFG_OFF, 1'b1, ST_NOT_IPV4);
        add_row(16'h0800, 8'h45, 16'h4000, PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002,
                16'd80, 16'd443, 12'd0, CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h4F, 16'h0000, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF,
                16'h0, 12'd0, CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h40, 16'h0000, PROTO_UDP, 32'h0, 32'hFFFF_FFFF, 16'h0,
                16'hFFFF, 12'd0, CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h44, 16'h0000, PROTO_TCP, 32'h1, 32'h2, 16'h1, 16'h2, 12'd0,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, 8'h01, 32'h0, 32'h0, 16'h0, 16'h0, 12'd0,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h46, 16'h0000, 8'hFF, 32'h0, 32'h0, 16'h0, 16'h0, 12'd50,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'hFFFF, PROTO_TCP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd60,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'hE000, PROTO_UDP, 32'h0, 32'h0, 16'h35, 16'h35, 12'd0,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd25,
                CFG_OFF, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 12'd37,
                CFG_OFF, 1'b0, ST_PENDING);
        // filters active
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A8_0002, 32'h0A00_0001,
                16'h1234, 16'hFFFF, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0002,
                16'h1234, 16'hFFFF, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0001,
                16'h1235, 16'hFFFF, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h47, 16'h0000, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0001,
                16'h1234, 16'hFFFE, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0001,
                16'h1234, 16'hFFFF, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A8_0001, 32'h0A00_0001,
                16'h1234, 16'hFFFF, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, 8'h01, 32'hC0A8_0001, 32'h0A00_0001,
                16'h0, 16'h0, 12'd0, CFG_A, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_TCP, 32'hFFFF_FFFF, 32'h1234_5678,
                16'h0, 16'hFFFF, 12'd0, CFG_B, 1'b0, ST_PENDING);
        add_row(16'h0800, 8'h45, 16'h0000, PROTO_UDP, 32'hFFFF_FFFE, 32'h0, 16'h0,
                16'hFFFF, 12'd0, CFG_B, 1'b0, ST_PENDING);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg != filter_cfg)
                apply_filters(directed_rows[i].cfg);
            send_frame(directed_rows[i]);
        end

        phase = 0;
        while (sent_bytes < 1400 || phase < 4)
        begin
            cfg = {$urandom, $urandom, $urandom};
            case (phase)
                0: cfg = '0;
                1: cfg = '1;
                2:
                begin
                    cfg.src_ip_filter[31:24] = 8'h00;
                    cfg.dst_ip_filter[31:24] = 8'h00;
                    cfg.dst_port_filter = 16'h0;
                end
                default:
                begin
                    cfg.src_ip_filter[31:24] = $urandom_range(0, 4) == 0
                                               ? 8'h00 : 8'($urandom_range(1, 255));
                    cfg.dst_ip_filter[31:24] = $urandom_range(0, 4) == 0
                                               ? 8'h00 : 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 3) == 0)
                        cfg.src_port_filter = 16'h0;
                    if ($urandom_range(0, 3) == 0)
                        cfg.dst_port_filter = 16'h0;
                end
            endcase
            apply_filters(cfg);
            idle_on = (phase % 4) != 3;
            for (int i = 0; i < 2; i++)
            begin
                row = random_row(cfg);
                send_frame(row);
                if ($urandom_range(0, 14) == 0)
                    wait_drained();
            end
            phase++;
        end

        frame_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ihf_pkg.sv
rtl/core/ihf_cfg.sv
rtl/core/ihf_parser.sv
rtl/core/ihf_out_skid.sv
rtl/core/ipv4_tcp_udp_header_filter_top.sv
rtl/core/ihf_checker.sv
bench/ipv4_tcp_udp_header_filter_top_tb.sv
